// ===== rtl/rhhs_pkg.sv =====
package rhhs_pkg;

   localparam int BUCKET_BITS = 8;
   localparam int COUNT_WIDTH = 32;
   localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
   localparam int TOP_N = 4;
   localparam int SIG_FIELD = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   typedef logic [BUCKET_BITS-1:0] bucket_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic       kind;
      bucket_type bucket;
   } work_type;

   typedef enum logic [1:0] {
      BK_RUN,
      BK_SCAN,
      BK_DRAIN,
      BK_EMIT
   } back_state_type;

   function automatic logic [31:0] mix_lo(input logic [31:0] k_in);
      logic [31:0] k;
      k = k_in;
      k = k + (k << 12);
      k = k ^ (k >> 22);
      k = k + (k << 4);
      k = k ^ (k >> 9);
      return k;
   endfunction

   function automatic logic [31:0] mix_hi(input logic [31:0] k_in);
      logic [31:0] k;
      k = k_in;
      k = k + (k << 10);
      k = k ^ (k >> 2);
      k = k + (k << 7);
      k = k + (k << 12);
      return k;
   endfunction

   function automatic logic [SIG_FIELD-1:0] sig_field(input bucket_type idx);
      logic [SIG_FIELD-1:0] f;
      f = '0;
      f[BUCKET_BITS-1:0] = idx;
      return f;
   endfunction

endpackage

// ===== rtl/rhhs_ram.sv =====
module rhhs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rhhs_queue.sv =====
module rhhs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rhhs_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_vld,
   output rhhs_pkg::work_type head_data
);
   import rhhs_pkg::*;

   work_type               slot_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (cnt_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_vld  = (cnt_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];

endmodule

// ===== rtl/rhhs_front.sv =====
module rhhs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [7:0]        req_data_byte,
   output logic              q_push,
   output rhhs_pkg::work_type q_data,
   input  logic              q_full
);
   import rhhs_pkg::*;

   logic [31:0] win_ff, win_in;
   logic [1:0]  seen_ff, seen_in;
   logic        f1_vld_ff, f1_vld_in;
   logic        f1_kind_ff, f1_kind_in;
   logic [31:0] f1_win_ff, f1_win_in;
   logic        f2_vld_ff, f2_vld_in;
   logic        f2_kind_ff, f2_kind_in;
   logic [31:0] f2_part_ff, f2_part_in;
   logic        f1_take, f2_take, accept;
   logic [31:0] win_next, hash;

   assign f2_take   = !f2_vld_ff || !q_full;
   assign f1_take   = !f1_vld_ff || f2_take;
   assign req_ready = f1_take;
   assign accept    = req_valid && req_ready;
   assign win_next  = {win_ff[23:0], req_data_byte};

   always_comb begin
      win_in     = win_ff;
      seen_in    = seen_ff;
      f1_vld_in  = f1_vld_ff;
      f1_kind_in = f1_kind_ff;
      f1_win_in  = f1_win_ff;
      if (f1_take) begin
         f1_vld_in  = 1'b0;
         f1_kind_in = req_kind;
         f1_win_in  = win_next;
      end
      if (accept) begin
         if (req_kind == KIND_FINAL) begin
            win_in    = '0;
            seen_in   = '0;
            f1_vld_in = 1'b1;
         end else begin
            win_in = win_next;
            if (&seen_ff) begin
               f1_vld_in = 1'b1;
            end else begin
               seen_in = seen_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      f2_vld_in  = f2_vld_ff;
      f2_kind_in = f2_kind_ff;
      f2_part_in = f2_part_ff;
      if (f2_take) begin
         f2_vld_in  = f1_vld_ff;
         f2_kind_in = f1_kind_ff;
         f2_part_in = mix_lo(f1_win_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff    <= '0;
         seen_ff   <= '0;
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else begin
         win_ff    <= win_in;
         seen_ff   <= seen_in;
         f1_vld_ff <= f1_vld_in;
         f2_vld_ff <= f2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      f1_kind_ff <= f1_kind_in;
      f1_win_ff  <= f1_win_in;
      f2_kind_ff <= f2_kind_in;
      f2_part_ff <= f2_part_in;
   end

   assign hash          = mix_hi(f2_part_ff);
   assign q_push        = f2_vld_ff && !q_full;
   assign q_data.kind   = f2_kind_ff;
   assign q_data.bucket = hash[BUCKET_BITS-1:0];

endmodule

// ===== rtl/rhhs_back.sv =====
module rhhs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_vld,
   input  rhhs_pkg::work_type q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_signature
);
   import rhhs_pkg::*;

   back_state_type         state_ff, state_in;
   logic                   b_vld_ff, b_vld_in;
   bucket_type             b_idx_ff, b_idx_in;
   logic                   fw_vld_ff;
   bucket_type             fw_idx_ff;
   count_type              fw_cnt_ff;
   bucket_type             scan_cnt_ff, scan_cnt_in;
   logic                   sc_vld_ff, sc_vld_in;
   bucket_type             sc_idx_ff, sc_idx_in;
   logic [NUM_BUCKETS-1:0] valid_ff, valid_in;
   bucket_type             top_idx_ff [0:TOP_N-1];
   bucket_type             top_idx_in [0:TOP_N-1];
   count_type              top_cnt_ff [0:TOP_N-1];
   count_type              top_cnt_in [0:TOP_N-1];
   logic [TOP_N-1:0]       top_vld_ff, top_vld_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_sig_ff, rsp_sig_in;
   logic                   scan_start, emit;
   bucket_type             rd_addr;
   count_type              rd_data, old_cnt, new_cnt, sc_cnt;
   logic [TOP_N-1:0]       gt;

   rhhs_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NUM_BUCKETS)
   ) u_hist (
      .clock   (clock),
      .wr_en   (b_vld_ff),
      .wr_addr (b_idx_ff),
      .wr_data (new_cnt),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      b_vld_in    = 1'b0;
      b_idx_in    = q_head.bucket;
      q_pop       = 1'b0;
      rd_addr     = q_head.bucket;
      scan_cnt_in = scan_cnt_ff;
      sc_vld_in   = 1'b0;
      sc_idx_in   = scan_cnt_ff;
      scan_start  = 1'b0;
      emit        = 1'b0;
      unique case (state_ff)
         BK_RUN: begin
            if (q_vld) begin
               if (q_head.kind == KIND_DATA) begin
                  q_pop    = 1'b1;
                  b_vld_in = 1'b1;
               end else if (!b_vld_ff) begin
                  q_pop       = 1'b1;
                  scan_start  = 1'b1;
                  scan_cnt_in = '0;
                  state_in    = BK_SCAN;
               end
            end
         end
         BK_SCAN: begin
            rd_addr     = scan_cnt_ff;
            sc_vld_in   = 1'b1;
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (&scan_cnt_ff) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               emit     = 1'b1;
               state_in = BK_RUN;
            end
         end
      endcase
   end

   always_comb begin
      if (fw_vld_ff && fw_idx_ff == b_idx_ff) begin
         old_cnt = fw_cnt_ff;
      end else if (valid_ff[b_idx_ff]) begin
         old_cnt = rd_data;
      end else begin
         old_cnt = '0;
      end
      new_cnt = (&old_cnt) ? old_cnt : old_cnt + 1'b1;
      sc_cnt  = valid_ff[sc_idx_ff] ? rd_data : '0;

      valid_in = valid_ff;
      if (emit) begin
         valid_in = '0;
      end else if (b_vld_ff) begin
         valid_in[b_idx_ff] = 1'b1;
      end
   end

   always_comb begin
      for (int k = 0; k < TOP_N; k++) begin
         gt[k] = !top_vld_ff[k] || (sc_cnt > top_cnt_ff[k]);
      end
      top_idx_in = top_idx_ff;
      top_cnt_in = top_cnt_ff;
      top_vld_in = top_vld_ff;
      if (scan_start) begin
         top_vld_in = '0;
      end else if (sc_vld_ff) begin
         if (gt[0]) begin
            top_idx_in[0] = sc_idx_ff;
            top_cnt_in[0] = sc_cnt;
            top_vld_in[0] = 1'b1;
         end
         for (int k = 1; k < TOP_N; k++) begin
            if (gt[k] && gt[k-1]) begin
               top_idx_in[k] = top_idx_ff[k-1];
               top_cnt_in[k] = top_cnt_ff[k-1];
               top_vld_in[k] = top_vld_ff[k-1];
            end else if (gt[k]) begin
               top_idx_in[k] = sc_idx_ff;
               top_cnt_in[k] = sc_cnt;
               top_vld_in[k] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sig_in   = rsp_sig_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_sig_in   = {sig_field(top_idx_ff[0]), sig_field(top_idx_ff[1]),
                         sig_field(top_idx_ff[2]), sig_field(top_idx_ff[3])};
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         b_vld_ff     <= 1'b0;
         fw_vld_ff    <= 1'b0;
         sc_vld_ff    <= 1'b0;
         scan_cnt_ff  <= '0;
         valid_ff     <= '0;
         top_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         b_vld_ff     <= b_vld_in;
         fw_vld_ff    <= b_vld_ff;
         sc_vld_ff    <= sc_vld_in;
         scan_cnt_ff  <= scan_cnt_in;
         valid_ff     <= valid_in;
         top_vld_ff   <= top_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_idx_ff   <= b_idx_in;
      fw_idx_ff  <= b_idx_ff;
      fw_cnt_ff  <= new_cnt;
      sc_idx_ff  <= sc_idx_in;
      top_idx_ff <= top_idx_in;
      top_cnt_ff <= top_cnt_in;
      rsp_sig_ff <= rsp_sig_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_signature = rsp_sig_ff;

endmodule

// ===== rtl/rolling_hash_histogram_signature.sv =====
// Channel   Ports                                    Beat
// req       req_valid req_ready req_kind             one data byte or a finalize
//           req_data_byte
// rsp       rsp_valid rsp_ready rsp_signature        one signature per finalize
//
// Data bytes sustain one beat per cycle while the queue is not full: one
// histogram read-modify-write each once the four-byte window is full. A
// finalize scans all buckets on the RAM read port once the queue ahead drains.
// Reset is synchronous; bucket valid bits clear at once, no clearing pass.
// A four-entry queue separates hashing from counting; each side stalls alone.
module rolling_hash_histogram_signature (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_signature
);
   import rhhs_pkg::*;

   logic     q_push, q_full, q_pop, q_vld;
   work_type q_in, q_head;

   rhhs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .q_push        (q_push),
      .q_data        (q_in),
      .q_full        (q_full)
   );

   rhhs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .head_vld  (q_vld),
      .head_data (q_head)
   );

   rhhs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_vld         (q_vld),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_signature (rsp_signature)
   );

`ifndef NO_ASSERTIONS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_vld)
      else $error("pop from empty queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
